FILE: hw/rtl/mkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

  localparam int LINE_LENGTH = 32;
  localparam int MAX_MARKS   = 5;
  localparam int COL_W       = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;
  localparam int KEY_W       = 8;
  localparam int CHAR_W      = 7;
  localparam int POS_W       = 5;
  localparam int CNT_W       = 3;
  localparam int IDX_W       = 2;

  localparam logic [IDX_W-1:0] REG_DOT_KEY  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DASH_KEY = 2'd1;
  localparam logic [IDX_W-1:0] REG_END_KEY  = 2'd2;

  localparam logic [KEY_W-1:0] DOT_KEY_RST  = 8'd122;
  localparam logic [KEY_W-1:0] DASH_KEY_RST = 8'd120;
  localparam logic [KEY_W-1:0] END_KEY_RST  = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd63;

  typedef struct packed {
    logic [KEY_W-1:0] dot_key;
    logic [KEY_W-1:0] dash_key;
    logic [KEY_W-1:0] end_key;
  } mkd_keys_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              known;
    logic [POS_W-1:0]  line_position;
    logic              clear_line;
  } mkd_result_t;

  typedef struct packed {
    logic              known;
    logic [CHAR_W-1:0] char_code;
  } mkd_glyph_t;

  // Index is (1 << count) | marks, dash = 1, first mark most significant.
  function automatic mkd_glyph_t morse_lookup(input logic [5:0] idx);
    mkd_glyph_t g;
    g.known = 1'b1;
    case (idx)
      6'd2:  g.char_code = 7'h45; // E
      6'd3:  g.char_code = 7'h54; // T
      6'd4:  g.char_code = 7'h49; // I
      6'd5:  g.char_code = 7'h41; // A
      6'd6:  g.char_code = 7'h4E; // N
      6'd7:  g.char_code = 7'h4D; // M
      6'd8:  g.char_code = 7'h53; // S
      6'd9:  g.char_code = 7'h55; // U
      6'd10: g.char_code = 7'h52; // R
      6'd11: g.char_code = 7'h57; // W
      6'd12: g.char_code = 7'h44; // D
      6'd13: g.char_code = 7'h4B; // K
      6'd14: g.char_code = 7'h47; // G
      6'd15: g.char_code = 7'h4F; // O
      6'd16: g.char_code = 7'h48; // H
      6'd17: g.char_code = 7'h56; // V
      6'd18: g.char_code = 7'h46; // F
      6'd20: g.char_code = 7'h4C; // L
      6'd22: g.char_code = 7'h50; // P
      6'd23: g.char_code = 7'h4A; // J
      6'd24: g.char_code = 7'h42; // B
      6'd25: g.char_code = 7'h58; // X
      6'd26: g.char_code = 7'h43; // C
      6'd27: g.char_code = 7'h59; // Y
      6'd28: g.char_code = 7'h5A; // Z
      6'd29: g.char_code = 7'h51; // Q
      6'd32: g.char_code = 7'h35; // 5
      6'd33: g.char_code = 7'h34; // 4
      6'd35: g.char_code = 7'h33; // 3
      6'd39: g.char_code = 7'h32; // 2
      6'd47: g.char_code = 7'h31; // 1
      6'd48: g.char_code = 7'h36; // 6
      6'd56: g.char_code = 7'h37; // 7
      6'd60: g.char_code = 7'h38; // 8
      6'd62: g.char_code = 7'h39; // 9
      6'd63: g.char_code = 7'h30; // 0
      default: begin
        g.known     = 1'b0;
        g.char_code = CHAR_UNKNOWN;
      end
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mkd_symbol.sv
`timescale 1ns / 1ps
`default_nettype none

module mkd_symbol (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [mkd_pkg::KEY_W-1:0] key,
  input  wire mkd_pkg::mkd_keys_t        keys,
  output      logic                      fire,
  output      mkd_pkg::mkd_result_t      result
);
  import mkd_pkg::*;

  logic [MAX_MARKS-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;

  logic                 is_dot;
  logic                 is_mark;
  logic [MAX_MARKS-1:0] bits_m;
  logic [CNT_W-1:0]     cnt_m;
  logic [5:0]           idx;
  logic                 wrap;
  mkd_glyph_t           glyph;

  assign is_dot  = (key == keys.dot_key);
  assign is_mark = is_dot || (key == keys.dash_key);
  assign bits_m  = is_mark ? {bits_r[MAX_MARKS-2:0], !is_dot} : bits_r;
  assign cnt_m   = is_mark ? cnt_r + 3'd1 : cnt_r;
  assign fire    = (key == keys.end_key) || (cnt_m >= CNT_W'(MAX_MARKS));

  always_comb begin
    case (cnt_m)
      3'd1:    idx = {5'b00001, bits_m[0]};
      3'd2:    idx = {4'b0001, bits_m[1:0]};
      3'd3:    idx = {3'b001, bits_m[2:0]};
      3'd4:    idx = {2'b01, bits_m[3:0]};
      3'd5:    idx = {1'b1, bits_m[4:0]};
      default: idx = 6'd0;
    endcase
  end

  assign glyph = morse_lookup(idx);
  assign wrap  = (col_r >= COL_W'(LINE_LENGTH - 1));

  always_comb begin
    result.char_code     = (cnt_m == 3'd0) ? CHAR_SPACE : glyph.char_code;
    result.known         = (cnt_m == 3'd0) ? 1'b1 : glyph.known;
    result.line_position = wrap ? '0 : POS_W'(col_r);
    result.clear_line    = wrap;
  end

  always_comb begin
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    if (step) begin
      if (fire) begin
        bits_nxt = '0;
        cnt_nxt  = '0;
        col_nxt  = wrap ? COL_W'(1) : col_r + COL_W'(1);
      end else begin
        bits_nxt = bits_m;
        cnt_nxt  = cnt_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      cnt_r  <= '0;
      col_r  <= '0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      col_r  <= col_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_MARKS))
    else $error("mark count reached limit without decode");

  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && fire |=> cnt_r == '0 && bits_r == '0)
    else $error("symbol not cleared after decode");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(LINE_LENGTH - 1))
    else $error("column beyond line");

endmodule

`default_nettype wire

FILE: hw/rtl/morse_key_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Morse key decoder. Each key byte item is a dot key, a dash key, an end key or
// ignored; up to five marks collect into a symbol that is decoded to ASCII on
// the end key or on the fifth mark, and an end key with no marks gives a space.
// Each decoded character leaves with its display column; when the column would
// reach the last position of the line, clear_line is set and the column starts
// again at 0. Unknown patterns give '?' with known low. Throughput is one item
// per cycle while out_ready does not hold a result: an item is registered in the
// input register, is decoded by the table lookup, and its result is held in the
// output register; out_valid rises only for an item that ends a symbol. A result
// held by a low out_ready stalls the input register, and then in_ready. Write
// the key registers only while idle.
module morse_key_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [mkd_pkg::KEY_W-1:0]  in_key_code,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [mkd_pkg::CHAR_W-1:0] out_char_code,
  output      logic                       out_known,
  output      logic [mkd_pkg::POS_W-1:0]  out_line_position,
  output      logic                       out_clear_line,
  input  wire logic                       cfg_we,
  input  wire logic [mkd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [mkd_pkg::KEY_W-1:0]  cfg_wdata
);
  import mkd_pkg::*;

  mkd_keys_t        keys_r, keys_nxt;
  logic             in_vld_r, in_vld_nxt;
  logic [KEY_W-1:0] in_key_r, in_key_nxt;
  logic             out_vld_r, out_vld_nxt;
  mkd_result_t      out_res_r, out_res_nxt;

  logic             adv;
  logic             step;
  logic             fire;
  mkd_result_t      res;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || adv;
  assign step     = in_vld_r && adv;

  mkd_symbol u_symbol (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .key    (in_key_r),
    .keys   (keys_r),
    .fire   (fire),
    .result (res)
  );

  always_comb begin
    keys_nxt = keys_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DOT_KEY:  keys_nxt.dot_key  = cfg_wdata;
        REG_DASH_KEY: keys_nxt.dash_key = cfg_wdata;
        REG_END_KEY:  keys_nxt.end_key  = cfg_wdata;
        default:      keys_nxt = keys_r;
      endcase
    end
  end

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_key_nxt  = in_key_r;
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
      in_key_nxt = in_key_code;
    end
    if (adv) begin
      out_vld_nxt = step && fire;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r    <= '{dot_key: DOT_KEY_RST, dash_key: DASH_KEY_RST, end_key: END_KEY_RST};
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      keys_r    <= keys_nxt;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_key_r  <= in_key_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_char_code     = out_res_r.char_code;
  assign out_known         = out_res_r.known;
  assign out_line_position = out_res_r.line_position;
  assign out_clear_line    = out_res_r.clear_line;

  a_unknown_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.known |-> out_res_r.char_code == CHAR_UNKNOWN)
    else $error("unknown pattern without question mark");

  a_clear_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.clear_line |-> out_res_r.line_position == '0)
    else $error("cleared line not at column zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_key_r))
    else $error("input register lost item during stall");

  a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_res_r))
    else $error("pending result changed");

endmodule

`default_nettype wire
